// ===== rtl/stid_pkg.sv =====
// types and codes shared by the sorted table core and its checker
`timescale 1ns / 1ps

package stid_pkg;

   // fixed field widths of the request and response beats
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;

   typedef logic [REQ_W-1:0]    req_code_type;
   typedef logic [STATUS_W-1:0] status_type;

   // request codes
   localparam req_code_type REQ_INSERT = 2'd0;
   localparam req_code_type REQ_DELETE = 2'd1;
   localparam req_code_type REQ_READ   = 2'd2;

   // response status codes
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;
   localparam status_type STATUS_RANGE     = 2'd3;

endpackage

// ===== rtl/sorted_table_insert_delete_core.sv =====
// Sorted table core: keeps up to DEPTH signed 32-bit values in ascending order in a
// synchronous memory with one read and one write port. An insert walks down from the
// top entry, moving each larger entry up one place before dropping the value in; a
// delete scans up from entry 0 for the first equal value and then moves the entries
// above it down one place; a read fetches one entry. Every visited entry takes a memory
// read and then a compare and, where an entry moves, a write back, since the read port
// is registered. An insert stops at a smaller or equal entry or at entry 0. A full
// insert, a delete on an empty table, an out-of-range read or an unused request goes
// straight to the response. One request is worked on at a time; a finished response
// waits in an output register, and a new request is taken meanwhile. The memory needs
// no clearing after reset: only entries below the count are ever used.
`timescale 1ns / 1ps

module sorted_table_insert_delete_core #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  stid_pkg::req_code_type               req_type,
   input  logic signed [stid_pkg::VALUE_W-1:0]  req_value,
   input  logic [stid_pkg::INDEX_W-1:0]         req_index,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output stid_pkg::status_type                 rsp_status,
   output logic signed [stid_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [stid_pkg::COUNT_W-1:0]         rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > stid_pkg::INDEX_W) ? CW : stid_pkg::INDEX_W;
   localparam int VW = stid_pkg::VALUE_W;

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_RD  = 4'd1;
   localparam logic [3:0] S_INS_CHK = 4'd2;
   localparam logic [3:0] S_INS_PUT = 4'd3;
   localparam logic [3:0] S_DEL_RD  = 4'd4;
   localparam logic [3:0] S_DEL_CHK = 4'd5;
   localparam logic [3:0] S_SH_RD   = 4'd6;
   localparam logic [3:0] S_SH_CHK  = 4'd7;
   localparam logic [3:0] S_RD_WAIT = 4'd8;
   localparam logic [3:0] S_PUSH    = 4'd9;

   logic [3:0]                 state_ff, state_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [CW-1:0]              ptr_ff, ptr_in;
   logic signed [VW-1:0]       val_ff, val_in;
   stid_pkg::status_type       status_ff, status_in;
   logic signed [VW-1:0]       data_ff, data_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   stid_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic signed [VW-1:0]       rsp_read_value_ff, rsp_read_value_in;
   logic [stid_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // table memory
   logic signed [VW-1:0]       mem [DEPTH];
   logic signed [VW-1:0]       mem_rdata_ff;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [AW-1:0]              mem_raddr;
   logic signed [VW-1:0]       mem_wdata;

   logic [CW-1:0]              ptr_nxt;
   logic [CW-1:0]              ptr_nxt2;
   logic [XW-1:0]              idx_x;
   logic [XW-1:0]              cnt_x;

   assign ptr_nxt  = ptr_ff + CW'(1);
   assign ptr_nxt2 = ptr_ff + CW'(2);
   assign idx_x    = XW'(req_index);
   assign cnt_x    = XW'(cnt_ff);

   // sequencer and datapath next values
   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      ptr_in            = ptr_ff;
      val_in            = val_ff;
      status_in         = status_ff;
      data_in           = data_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_count_in      = rsp_count_ff;
      mem_we            = 1'b0;
      mem_waddr         = ptr_ff[AW-1:0];
      mem_wdata         = val_ff;
      mem_raddr         = ptr_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in    = req_value;
               status_in = stid_pkg::STATUS_OK;
               data_in   = '0;
               unique case (req_type)
                  stid_pkg::REQ_INSERT: begin
                     if (cnt_ff >= CW'(DEPTH)) begin
                        status_in = stid_pkg::STATUS_FULL;
                        state_in  = S_PUSH;
                     end else if (cnt_ff == '0) begin
                        ptr_in   = '0;
                        state_in = S_INS_PUT;
                     end else begin
                        ptr_in   = cnt_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  stid_pkg::REQ_DELETE: begin
                     if (cnt_ff == '0) begin
                        status_in = stid_pkg::STATUS_NOT_FOUND;
                        state_in  = S_PUSH;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_DEL_RD;
                     end
                  end
                  stid_pkg::REQ_READ: begin
                     if (idx_x < cnt_x) begin
                        mem_raddr = AW'(req_index);
                        state_in  = S_RD_WAIT;
                     end else begin
                        status_in = stid_pkg::STATUS_RANGE;
                        state_in  = S_PUSH;
                     end
                  end
                  default: begin
                     state_in = S_PUSH;
                  end
               endcase
            end
         end

         // insert: fetch the entry below the hole
         S_INS_RD: begin
            mem_raddr = AW'(ptr_ff - CW'(1));
            state_in  = S_INS_CHK;
         end

         // insert: move a larger entry up, or drop the value into the hole
         S_INS_CHK: begin
            mem_we = 1'b1;
            if (mem_rdata_ff > val_ff) begin
               mem_wdata = mem_rdata_ff;
               ptr_in    = ptr_ff - CW'(1);
               state_in  = (ptr_ff == CW'(1)) ? S_INS_PUT : S_INS_RD;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_PUSH;
            end
         end

         S_INS_PUT: begin
            mem_we   = 1'b1;
            cnt_in   = cnt_ff + CW'(1);
            state_in = S_PUSH;
         end

         // delete: scan for the first equal entry
         S_DEL_RD: begin
            state_in = S_DEL_CHK;
         end

         S_DEL_CHK: begin
            if (mem_rdata_ff == val_ff) begin
               if (ptr_nxt < cnt_ff) begin
                  state_in = S_SH_RD;
               end else begin
                  cnt_in   = cnt_ff - CW'(1);
                  state_in = S_PUSH;
               end
            end else if (ptr_nxt < cnt_ff) begin
               ptr_in   = ptr_nxt;
               state_in = S_DEL_RD;
            end else begin
               status_in = stid_pkg::STATUS_NOT_FOUND;
               state_in  = S_PUSH;
            end
         end

         // delete: close the gap one entry at a time
         S_SH_RD: begin
            mem_raddr = ptr_nxt[AW-1:0];
            state_in  = S_SH_CHK;
         end

         S_SH_CHK: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata_ff;
            ptr_in    = ptr_nxt;
            if (ptr_nxt2 < cnt_ff) begin
               state_in = S_SH_RD;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = S_PUSH;
            end
         end

         S_RD_WAIT: begin
            data_in  = mem_rdata_ff;
            state_in = S_PUSH;
         end

         // hand the result to the output register once it is free
         S_PUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_read_value_in = data_ff;
               rsp_count_in      = stid_pkg::COUNT_W'(cnt_ff);
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff            <= ptr_in;
      val_ff            <= val_in;
      status_ff         <= status_in;
      data_ff           <= data_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_count_ff      <= rsp_count_in;
   end

   // memory port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

// ===== rtl/stid_checker.sv =====
// port checker for the sorted table core, bound into the core module
`timescale 1ns / 1ps

module stid_checker #(
   parameter int DEPTH = 64
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input stid_pkg::status_type                 rsp_status,
   input logic signed [stid_pkg::VALUE_W-1:0]  rsp_read_value,
   input logic [stid_pkg::COUNT_W-1:0]         rsp_count
);

   // no response beat straight out of reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   // a stalled response beat stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_count))
      else $error("stalled response beat changed");

   // an error response carries zero data
   a_err_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != stid_pkg::STATUS_OK |-> rsp_read_value == '0)
      else $error("error response with nonzero data");

   // a full report only comes with a full table
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == stid_pkg::STATUS_FULL
         |-> rsp_count == stid_pkg::COUNT_W'(DEPTH))
      else $error("table full reported below capacity");

endmodule

bind sorted_table_insert_delete_core stid_checker #(.DEPTH(DEPTH)) u_stid_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_read_value (rsp_read_value),
   .rsp_count      (rsp_count)
);

// ===== sim/tb_sorted_table_insert_delete_core.sv =====
// testbench for the sorted table core: directed and random requests checked against a shadow table
`timescale 1ns / 1ps

module tb_sorted_table_insert_delete_core;

   localparam int DEPTH = 64;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES = 200;
   // unused request code, answered with status ok and no table change
   localparam stid_pkg::req_code_type REQ_UNUSED = 2'd3;

   typedef logic signed [stid_pkg::VALUE_W-1:0] value_type;
   typedef logic [stid_pkg::INDEX_W-1:0]        index_type;
   typedef logic [stid_pkg::COUNT_W-1:0]        count_type;

   typedef struct {
      stid_pkg::status_type   status;
      value_type              value;
      count_type              count;
   } response_type;

   // shadow of the sorted table and the responses it predicts
   class table_scoreboard;
      value_type    shadow[DEPTH];
      int           held;
      response_type expected_q[$];
      int           errors;
      int           reported;

      function new();
         held = 0;
         errors = 0;
         reported = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // apply one accepted request beat to the shadow table
      function void note_request(stid_pkg::req_code_type kind, value_type v,
                                 index_type idx);
         response_type r;
         int p;
         r.status = stid_pkg::STATUS_OK;
         r.value = '0;
         case (kind)
            stid_pkg::REQ_INSERT: begin
               if (held >= DEPTH) begin
                  r.status = stid_pkg::STATUS_FULL;
               end else begin
                  p = held;
                  while (p > 0 && shadow[p-1] > v) begin
                     shadow[p] = shadow[p-1];
                     p--;
                  end
                  shadow[p] = v;
                  held++;
               end
            end
            stid_pkg::REQ_DELETE: begin
               p = 0;
               while (p < held && shadow[p] != v) p++;
               if (p == held) begin
                  r.status = stid_pkg::STATUS_NOT_FOUND;
               end else begin
                  for (; p + 1 < held; p++) shadow[p] = shadow[p+1];
                  held--;
               end
            end
            stid_pkg::REQ_READ: begin
               if (idx < held) r.value = shadow[idx];
               else r.status = stid_pkg::STATUS_RANGE;
            end
            default: ;
         endcase
         r.count = held[stid_pkg::COUNT_W-1:0];
         expected_q.push_back(r);
      endfunction

      // compare one accepted response beat with the oldest prediction
      function void check_response(stid_pkg::status_type s, value_type v, count_type c);
         response_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("unexpected response: status %0d value %0d count %0d", s, v, c);
            end
            return;
         end
         e = expected_q.pop_front();
         if (e.status !== s || e.value !== v || e.count !== c) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("mismatch: expected status %0d value %0d count %0d,",
                        e.status, e.value, e.count,
                        " got status %0d value %0d count %0d", s, v, c);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   stid_pkg::req_code_type req_type = stid_pkg::REQ_INSERT;
   value_type              req_value = '0;
   index_type              req_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   stid_pkg::status_type   rsp_status;
   value_type              rsp_read_value;
   count_type              rsp_count;

   bit gaps_on = 1'b1;
   bit holdoff_req = 1'b0;

   table_scoreboard sb = new();

   sorted_table_insert_delete_core #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_value(req_value),
      .req_index(req_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_read_value(rsp_read_value),
      .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // receiver: random stalls, or a long counted hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (holdoff_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            holdoff_req = 1'b0;
         end else begin
            rsp_stall <= gaps_on && ($urandom_range(99) < 29);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_read_value, rsp_count);
   end

   // offer one request beat and hold it until it is taken
   task automatic issue(stid_pkg::req_code_type kind, value_type value, index_type idx);
      if (gaps_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_value <= value;
      req_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(kind, value, idx);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // values biased towards table contents, duplicates and extremes
   function automatic value_type pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45 && sb.held > 0) return sb.shadow[$urandom_range(sb.held - 1)];
      if (roll < 60) return value_type'($urandom_range(15)) - 8;
      if (roll < 66) return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      return value_type'($urandom);
   endfunction

   // random requests with the given insert and delete shares in percent
   task automatic random_run(int n, int ins_pct, int del_pct);
      int roll;
      stid_pkg::req_code_type kind;
      index_type idx;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < ins_pct) kind = stid_pkg::REQ_INSERT;
         else if (roll < ins_pct + del_pct) kind = stid_pkg::REQ_DELETE;
         else if (roll < 95) kind = stid_pkg::REQ_READ;
         else kind = REQ_UNUSED;
         if (kind == stid_pkg::REQ_READ && sb.held > 0 && $urandom_range(99) < 70)
            idx = stid_pkg::INDEX_W'($urandom_range(sb.held - 1));
         else
            idx = stid_pkg::INDEX_W'($urandom_range(63));
         issue(kind, pick_value(), idx);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table corner cases
      issue(stid_pkg::REQ_READ, 0, 0);
      issue(stid_pkg::REQ_DELETE, 5, 0);
      issue(REQ_UNUSED, 0, 0);
      // extremes, zero, minus one and a duplicate
      issue(stid_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 0);
      issue(stid_pkg::REQ_INSERT, 32'sh8000_0000, 63);
      issue(stid_pkg::REQ_INSERT, 0, 0);
      issue(stid_pkg::REQ_INSERT, -1, 0);
      issue(stid_pkg::REQ_INSERT, 0, 0);
      for (int i = 0; i < 6; i++) issue(stid_pkg::REQ_READ, 0, stid_pkg::INDEX_W'(i));
      issue(stid_pkg::REQ_READ, 0, 63);
      // duplicate delete removes only one
      issue(stid_pkg::REQ_DELETE, 0, 0);
      issue(stid_pkg::REQ_READ, 0, 1);
      issue(stid_pkg::REQ_DELETE, 32'sh8000_0000, 0);
      issue(stid_pkg::REQ_DELETE, 32'sh7FFF_FFFF, 0);
      issue(stid_pkg::REQ_DELETE, 12345, 0);
      issue(REQ_UNUSED, -1, 63);
      issue(stid_pkg::REQ_READ, 0, 0);

      // mixed traffic with gaps
      random_run(180, 40, 30);

      // long calm stretch, no gaps either side
      gaps_on = 1'b0;
      random_run(100, 40, 30);
      gaps_on = 1'b1;

      // receiver holds off while requests keep coming
      holdoff_req = 1'b1;
      random_run(40, 50, 20);
      wait_drained();

      // fill to full and beyond
      random_run(150, 80, 10);
      wait_drained();

      // drain to empty
      random_run(150, 10, 80);

      // mixed again
      random_run(110, 40, 30);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/stid_pkg.sv
rtl/sorted_table_insert_delete_core.sv
rtl/stid_checker.sv
sim/tb_sorted_table_insert_delete_core.sv
